[hw/rtl/fvwu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fvwu_pkg;

    // payload widths
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 7;
    localparam int HALF_W  = 24;
    localparam int CFG_W   = 7;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_RAW_FLOAT_MODE     = 1'b0,
        CFG_START_VECTOR_INDEX = 1'b1
    } cfg_index_t;

    // word position within the vector being assembled
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;
    localparam logic [1:0] PHASE_FOURTH = 2'd3;

    // exponent constants for widening a 24-bit float
    localparam logic [6:0] EXP24_ALL_ONES = 7'h7f;
    localparam logic [7:0] EXP_ADJUST     = 8'h40;
    localparam logic [7:0] EXP32_ALL_ONES = 8'hff;

    // widen a 24-bit float to ieee single bits
    function automatic logic [WORD_W-1:0] widen24(input logic [HALF_W-1:0] v);
        logic       s;
        logic [6:0] e;
        logic [15:0] m;
        logic [7:0] e_out;
        s = v[23];
        e = v[22:16];
        m = v[15:0];
        if ((e == 7'd0) && (m == 16'd0))
        begin
            e_out = 8'd0;
        end
        else if (e == EXP24_ALL_ONES)
        begin
            e_out = EXP32_ALL_ONES;
        end
        else
        begin
            e_out = {1'b0, e} + EXP_ADJUST;
        end
        return {s, e_out, m, 7'd0};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/fvwu_word_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fvwu_word_if;
    logic                        valid;
    logic                        ready;
    logic [fvwu_pkg::WORD_W-1:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

`default_nettype wire

[hw/rtl/fvwu_vector_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fvwu_vector_if;
    logic                         valid;
    logic                         ready;
    logic [fvwu_pkg::INDEX_W-1:0] vector_index;
    logic [fvwu_pkg::WORD_W-1:0]  comp_x;
    logic [fvwu_pkg::WORD_W-1:0]  comp_y;
    logic [fvwu_pkg::WORD_W-1:0]  comp_z;
    logic [fvwu_pkg::WORD_W-1:0]  comp_w;

    modport source (output valid, output vector_index, output comp_x, output comp_y,
                    output comp_z, output comp_w, input ready);
    modport sink   (input valid, input vector_index, input comp_x, input comp_y,
                    input comp_z, input comp_w, output ready);
endinterface

`default_nettype wire

[hw/rtl/float_vector_word_unpacker_unit.sv]
// float vector word unpacker
//
// upload: valid/ready channel of 32-bit upload words for shader constant
// vectors. vector: valid/ready channel of completed vectors (index and four
// ieee single components). cfg_we/cfg_index/cfg_data write the two registers:
// index 0 selects raw mode (four words per vector) or packed mode (three words
// carrying four 24-bit floats, w first); index 1 sets the next vector index.
// write configuration only while no vector is partly delivered.
//
// one upload word is taken every cycle. the vector appears on the output
// register in the cycle after the transaction of its last word; the word path
// is a single stage of merge, exponent add and select into that register.
// reset clears the word phase, carries, partial components and the index to 0
// and selects packed mode. while the receiver stalls with a vector held in the
// output register, upload ready stays low and no word is taken, whether or not
// it would complete a vector, until the held vector is taken.
`timescale 1ns / 1ps
`default_nettype none

module float_vector_word_unpacker_unit #(
    parameter int VECTOR_COUNT = 96
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_we,
    input  wire                         cfg_index,
    input  wire [fvwu_pkg::CFG_W-1:0]   cfg_data,
    fvwu_word_if.sink                   upload,
    fvwu_vector_if.source               vector
);

    localparam logic [fvwu_pkg::INDEX_W:0] COUNT_LIMIT = (fvwu_pkg::INDEX_W + 1)'(VECTOR_COUNT);

    // state
    logic                          raw_mode_reg;
    logic [1:0]                    phase_reg, phase_next;
    logic [fvwu_pkg::HALF_W-1:0]   carry_reg, carry_next;
    logic [fvwu_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic [fvwu_pkg::WORD_W-1:0]   part_reg [3];
    logic [fvwu_pkg::WORD_W-1:0]   part_next [3];

    // output register
    logic                          out_valid_reg;
    logic [fvwu_pkg::INDEX_W-1:0]  out_index_reg;
    logic [fvwu_pkg::WORD_W-1:0]   out_x_reg, out_y_reg, out_z_reg, out_w_reg;

    logic                          accept;
    logic                          done;
    logic [fvwu_pkg::WORD_W-1:0]   res_x, res_y;
    logic [fvwu_pkg::INDEX_W:0]    index_inc;

    // accept while the output register is free or being drained
    assign upload.ready = !out_valid_reg || vector.ready;
    assign accept       = upload.valid && upload.ready;

    assign index_inc = {1'b0, index_reg} + 1'b1;

    // word assembly
    always_comb
    begin
        phase_next = phase_reg;
        carry_next = carry_reg;
        part_next  = part_reg;
        done       = 1'b0;
        res_x      = upload.data_word;
        res_y      = part_reg[2];
        if (raw_mode_reg)
        begin
            if (phase_reg != fvwu_pkg::PHASE_FOURTH)
            begin
                part_next[phase_reg] = upload.data_word;
                phase_next           = phase_reg + 2'd1;
            end
            else
            begin
                done       = 1'b1;
                phase_next = fvwu_pkg::PHASE_FIRST;
            end
        end
        else
        begin
            case (phase_reg)
                fvwu_pkg::PHASE_SECOND:
                begin
                    part_next[1] = fvwu_pkg::widen24(carry_reg | {8'd0, upload.data_word[31:16]});
                    carry_next   = {upload.data_word[15:0], 8'd0};
                    phase_next   = fvwu_pkg::PHASE_THIRD;
                end
                fvwu_pkg::PHASE_THIRD:
                begin
                    res_y        = fvwu_pkg::widen24(carry_reg | {16'd0, upload.data_word[31:24]});
                    res_x        = fvwu_pkg::widen24(upload.data_word[23:0]);
                    part_next[2] = res_y;
                    done         = 1'b1;
                    phase_next   = fvwu_pkg::PHASE_FIRST;
                end
                default:
                begin
                    part_next[0] = fvwu_pkg::widen24(upload.data_word[31:8]);
                    carry_next   = {upload.data_word[7:0], 16'd0};
                    phase_next   = fvwu_pkg::PHASE_SECOND;
                end
            endcase
        end
    end

    // index advance with wrap
    always_comb
    begin
        index_next = index_reg;
        if (cfg_we && (cfg_index == fvwu_pkg::CFG_START_VECTOR_INDEX))
        begin
            index_next = cfg_data[fvwu_pkg::INDEX_W-1:0];
        end
        else if (accept && done)
        begin
            index_next = (index_inc >= COUNT_LIMIT) ? '0 : index_inc[fvwu_pkg::INDEX_W-1:0];
        end
    end

    // control and assembly state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_mode_reg <= 1'b0;
            phase_reg    <= fvwu_pkg::PHASE_FIRST;
            carry_reg    <= '0;
            index_reg    <= '0;
            part_reg[0]  <= '0;
            part_reg[1]  <= '0;
            part_reg[2]  <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == fvwu_pkg::CFG_RAW_FLOAT_MODE))
            begin
                raw_mode_reg <= cfg_data[0];
            end
            index_reg <= index_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                carry_reg <= carry_next;
                part_reg  <= part_next;
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (vector.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept && done)
        begin
            out_index_reg <= index_reg;
            out_x_reg     <= res_x;
            out_y_reg     <= res_y;
            out_z_reg     <= part_reg[1];
            out_w_reg     <= part_reg[0];
        end
    end

    assign vector.valid        = out_valid_reg;
    assign vector.vector_index = out_index_reg;
    assign vector.comp_x       = out_x_reg;
    assign vector.comp_y       = out_y_reg;
    assign vector.comp_z       = out_z_reg;
    assign vector.comp_w       = out_w_reg;

    // a stalled full output register blocks new words
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !vector.ready) |-> !upload.ready)
        else $error("upload ready while output register is held");

    // the last packed word produces a vector
    a_packed_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !raw_mode_reg && (phase_reg == fvwu_pkg::PHASE_THIRD)) |=> out_valid_reg)
        else $error("packed vector not delivered");

    // a first packed word moves to the second phase
    a_packed_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !raw_mode_reg && (phase_reg == fvwu_pkg::PHASE_FIRST))
        |=> (phase_reg == fvwu_pkg::PHASE_SECOND))
        else $error("packed phase did not advance");

    // an advanced index stays within the vector count
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done && !cfg_we) |=> ({1'b0, index_reg} < COUNT_LIMIT))
        else $error("vector index beyond count after advance");

    // a word that completes nothing leaves the output empty unless it was held
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !(accept && done)) |=> !out_valid_reg)
        else $error("vector produced without completion");

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import fvwu_pkg::*;

    localparam int VECTOR_COUNT = 96;
    localparam int TARGET_WORDS = 1500;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [WORD_W-1:0]  x;
        logic [WORD_W-1:0]  y;
        logic [WORD_W-1:0]  z;
        logic [WORD_W-1:0]  w;
    } const_vector_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    fvwu_word_if   upload_if ();
    fvwu_vector_if vector_if ();

    float_vector_word_unpacker_unit #(
        .VECTOR_COUNT (VECTOR_COUNT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .upload    (upload_if.sink),
        .vector    (vector_if.source)
    );

    // words waiting to be offered and vectors waiting to come out
    logic [WORD_W-1:0] upload_words[$];
    const_vector_t     vectors_due[$];
    bit                offer_live;
    bit                calm;
    int                hold_asked;
    int                hold_seen;
    int                hold_left;
    int                error_count;
    int                words_queued;

    // shadow of the unpacker state
    logic              raw_mode;
    logic [1:0]        word_phase;
    logic [23:0]       carry_bits;
    logic [INDEX_W-1:0] next_index;
    logic [WORD_W-1:0] partial[3];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    // 24-bit float to ieee single bits
    function automatic logic [WORD_W-1:0] to_single(input logic [23:0] v);
        logic [7:0] exp_out;
        if (v[22:0] == 23'd0)
        begin
            exp_out = 8'h00;
        end
        else if (v[22:16] == 7'h7f)
        begin
            exp_out = 8'hff;
        end
        else
        begin
            exp_out = {1'b0, v[22:16]} + 8'h40;
        end
        return {v[23], exp_out, v[15:0], 7'd0};
    endfunction

    // finish a vector and step the index with wrap
    task automatic emit_vector(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y);
        const_vector_t v;
        int            n;
        v.index = next_index;
        v.x     = x;
        v.y     = y;
        v.z     = partial[1];
        v.w     = partial[0];
        vectors_due.push_back(v);
        word_phase = PHASE_FIRST;
        n = int'(next_index) + 1;
        next_index = (n >= VECTOR_COUNT) ? '0 : n[INDEX_W-1:0];
    endtask

    // fold one accepted upload word into the shadow state
    task automatic unpack_word(input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] y;
        if (raw_mode)
        begin
            if (word_phase != PHASE_FOURTH)
            begin
                partial[word_phase] = d;
                word_phase = word_phase + 2'd1;
            end
            else
            begin
                emit_vector(d, partial[2]);
            end
        end
        else if (word_phase == PHASE_FIRST || word_phase == PHASE_FOURTH)
        begin
            partial[0] = to_single(d[31:8]);
            carry_bits = {d[7:0], 16'd0};
            word_phase = PHASE_SECOND;
        end
        else if (word_phase == PHASE_SECOND)
        begin
            partial[1] = to_single({carry_bits[23:16], d[31:16]});
            carry_bits = {d[15:0], 8'd0};
            word_phase = PHASE_THIRD;
        end
        else
        begin
            y = to_single({carry_bits[23:8], d[31:24]});
            partial[2] = y;
            emit_vector(to_single(d[23:0]), y);
        end
    endtask

    function automatic logic [23:0] rand_float24();
        logic        s;
        logic [31:0] r;
        s = $urandom_range(0, 1);
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return {s, 23'd0};
            1: return {s, 7'h7f, r[15:0]};
            2: return {s, 7'h00, r[15:0]};
            3: return {s, 7'h7f, 16'd0};
            default: return r[23:0];
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_raw_word();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_word(input logic [WORD_W-1:0] d);
        upload_words.push_back(d);
        words_queued++;
    endtask

    // three packed words carrying w, z, y, x
    task automatic push_packed(input logic [23:0] w, input logic [23:0] z,
                               input logic [23:0] y, input logic [23:0] x);
        push_word({w, z[23:16]});
        push_word({z[15:0], y[23:8]});
        push_word({y[7:0], x});
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == CFG_RAW_FLOAT_MODE)
        begin
            raw_mode = value[0];
        end
        else
        begin
            next_index = value;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_mode(input logic mode);
        logic [CFG_W-1:0] v;
        v    = $urandom;
        v[0] = mode;
        write_reg(CFG_RAW_FLOAT_MODE, v);
    endtask

    // wait until every word is taken and every vector has come out
    task automatic drain();
        while (upload_words.size() != 0 || offer_live || vectors_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // upload driver: offer the next word at the falling edge
    always @(negedge clk)
    begin
        if (!offer_live)
        begin
            if (rst_n && upload_words.size() != 0 && (calm || $urandom_range(0, 99) >= 24))
            begin
                upload_if.valid     <= 1'b1;
                upload_if.data_word <= upload_words[0];
                offer_live = 1'b1;
            end
            else
            begin
                upload_if.valid <= 1'b0;
            end
        end
    end

    // upload transaction: update the shadow state
    always @(posedge clk)
    begin
        if (rst_n && upload_if.valid && upload_if.ready)
        begin
            unpack_word(upload_if.data_word);
            void'(upload_words.pop_front());
            offer_live = 1'b0;
        end
    end

    // vector ready with random stalls and a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            vector_if.ready <= 1'b0;
        end
        else
        begin
            vector_if.ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    // vector monitor
    always @(posedge clk)
    begin
        const_vector_t exp_v;
        if (rst_n && vector_if.valid && vector_if.ready)
        begin
            if (vectors_due.size() == 0)
            begin
                $display("%0t: unexpected vector, expected none, actual index %h x %h",
                         $time, vector_if.vector_index, vector_if.comp_x);
                error_count++;
            end
            else
            begin
                exp_v = vectors_due.pop_front();
                check_field("vector_index", 32'(exp_v.index), 32'(vector_if.vector_index));
                check_field("comp_x", exp_v.x, vector_if.comp_x);
                check_field("comp_y", exp_v.y, vector_if.comp_y);
                check_field("comp_z", exp_v.z, vector_if.comp_z);
                check_field("comp_w", exp_v.w, vector_if.comp_w);
            end
        end
    end

    // stimulus
    initial
    begin
        int          phase;
        int          n_vec;
        int          n_extra;
        logic [31:0] r;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_RAW_FLOAT_MODE;
        cfg_data            = '0;
        upload_if.valid     = 1'b0;
        upload_if.data_word = '0;
        vector_if.ready     = 1'b0;
        offer_live          = 1'b0;
        calm                = 1'b0;
        hold_asked          = 0;
        hold_seen           = 0;
        hold_left           = 0;
        error_count         = 0;
        words_queued        = 0;
        raw_mode            = 1'b0;
        word_phase          = PHASE_FIRST;
        carry_bits          = '0;
        next_index          = '0;
        partial[0]          = '0;
        partial[1]          = '0;
        partial[2]          = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // packed extremes: signed zeros, all ones, inf/nan exponents, denormal-like
        write_mode(1'b0);
        write_reg(CFG_START_VECTOR_INDEX, 7'd0);
        push_packed(24'h000000, 24'h800000, 24'h000000, 24'h800000);
        push_packed(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
        push_packed(24'h7f0000, 24'hff1234, 24'h000001, 24'h010000);
        push_packed(24'h3fabcd, 24'h40abcd, 24'hc00000, 24'h7effff);
        drain();

        // raw mode at the last vector, then a vector left three words in
        write_mode(1'b1);
        write_reg(CFG_START_VECTOR_INDEX, 7'd95);
        push_word(32'h0000_0000);
        push_word(32'hffff_ffff);
        push_word(32'h8000_0000);
        push_word(32'h7fff_ffff);
        push_word(32'h3f80_0000);
        push_word(32'h0000_0001);
        push_word(32'hffff_fffe);
        drain();

        // packed mode restarts a raw vector left at its fourth word; index past the count
        write_mode(1'b0);
        write_reg(CFG_START_VECTOR_INDEX, 7'd127);
        push_packed(24'h123456, 24'h876543, 24'h7f8001, 24'h00ffff);
        push_word(32'h4000_00aa);
        drain();

        // index write and switch to raw in the middle of a vector
        write_reg(CFG_START_VECTOR_INDEX, 7'd50);
        write_mode(1'b1);
        push_word(32'hdead_beef);
        push_word(32'h5555_aaaa);
        push_word(32'haaaa_5555);
        drain();

        // random phases under changing settings
        phase = 0;
        words_queued = 0;
        while (words_queued < TARGET_WORDS)
        begin
            calm = (phase == 3);
            if (phase == 0 || $urandom_range(0, 1) == 1)
            begin
                write_mode($urandom_range(0, 1));
            end
            if (phase == 0 || $urandom_range(0, 2) != 0)
            begin
                case (phase % 4)
                    0: write_reg(CFG_START_VECTOR_INDEX, 7'd127);
                    1: write_reg(CFG_START_VECTOR_INDEX, 7'd95);
                    default:
                    begin
                        r = $urandom;
                        write_reg(CFG_START_VECTOR_INDEX, r[6:0]);
                    end
                endcase
            end
            if (phase == 5)
            begin
                hold_asked++;
            end
            n_vec = $urandom_range(20, 50);
            for (int i = 0; i < n_vec; i++)
            begin
                if (raw_mode)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        push_word(rand_raw_word());
                    end
                end
                else
                begin
                    push_packed(rand_float24(), rand_float24(), rand_float24(),
                                rand_float24());
                end
            end
            // sometimes leave a vector unfinished across the settings change
            n_extra = $urandom_range(0, 3);
            for (int i = 0; i < n_extra; i++)
            begin
                push_word(rand_raw_word());
            end
            drain();
            phase++;
        end
        calm = 1'b0;

        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
